// ----- design/csa_pkg.sv -----
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the circular next-free-slot allocator:
// result codes, request codes, datapath operations, controller states and
// the command and status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package csa_pkg;

    // Fixed widths of the external fields.
    localparam int SLOT_W = 10;
    localparam int CFG_W  = 11;

    // Request codes.
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Result codes.
    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_FULL     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_BAD      = 2'd3
    } status_t;

    // Operations the controller asks of the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CFG,
        OP_SWEEP,
        OP_LOAD,
        OP_READ_NODE,
        OP_TO_SIB,
        OP_UP,
        OP_ROOT,
        OP_READ_LEFT,
        OP_DOWN_LEFT,
        OP_DOWN_RIGHT,
        OP_FOUND,
        OP_WRITE_UPD,
        OP_RESULT
    } dp_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_REL_CHK,
        S_UP_CHK,
        S_UP_STEP,
        S_SIB_CHK,
        S_DOWN_STEP,
        S_DOWN_CHK,
        S_WRAP_CHK,
        S_UPD_RD,
        S_UPD_WR,
        S_FINISH
    } state_t;

    // Command word from controller to datapath.
    typedef struct packed {
        dp_op_t  op;
        status_t st;
    } cmd_t;

    // Status word from datapath to controller.
    typedef struct packed {
        logic cnt_nz;
        logic at_root;
        logic is_left;
        logic is_leaf;
        logic start_oob;
        logic is_release;
        logic sweep_last;
    } stat_t;

endpackage

// ----- design/csa_ram.sv -----
// ----------------------------------------------------------------------------
// csa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module csa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/csa_dp.sv -----
// ----------------------------------------------------------------------------
// csa_dp
// Datapath of the allocator: the free-count tree memory, the node pointer
// that walks it, the clearing sweep that rebuilds it and the result
// registers.
// ----------------------------------------------------------------------------
module csa_dp #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csa_pkg::cmd_t               cmd,
    output csa_pkg::stat_t              stat,
    input  logic                        func,
    input  logic [csa_pkg::SLOT_W-1:0]  slot,
    input  logic [csa_pkg::CFG_W-1:0]   slots_in_use,
    output logic                        done,
    output logic [csa_pkg::SLOT_W-1:0]  granted_slot,
    output csa_pkg::status_t            status
);

    // Leaves are padded to a power of two; nodes are numbered from 1.
    localparam int LW    = $clog2(MAX_SLOTS);
    localparam int NW    = LW + 1;
    localparam int CW    = LW + 1;
    localparam int DEPTH = 2 ** NW;
    localparam int CMPW  = (CW > csa_pkg::CFG_W) ? CW : csa_pkg::CFG_W;

    logic [CW-1:0]   n_reg, n_next;
    logic [NW-1:0]   sw_idx_reg, sw_idx_next;
    logic [CW-1:0]   sw_lo_reg, sw_lo_next;
    logic [CW-1:0]   sw_span_reg, sw_span_next;
    logic [NW-1:0]   node_reg, node_next;
    logic [NW-1:0]   leaf_reg, leaf_next;
    logic            func_reg, func_next;
    logic [csa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic            done_reg, done_next;
    logic [csa_pkg::SLOT_W-1:0] granted_reg, granted_next;
    csa_pkg::status_t status_reg, status_next;

    logic            ram_we;
    logic [NW-1:0]   ram_waddr;
    logic [CW-1:0]   ram_wdata;
    logic            ram_re;
    logic [NW-1:0]   ram_raddr;
    logic [CW-1:0]   ram_rdata;

    logic [CMPW-1:0] cfg_ext;
    logic [CMPW-1:0] slot_ext;
    logic [CMPW-1:0] leaf_ext;
    logic [CW-1:0]   sw_diff;
    logic [CW-1:0]   sw_cnt;
    logic [NW:0]     sw_inc;
    logic            sw_level_end;
    logic [NW-1:0]   sib_addr;
    logic [NW-1:0]   left_addr;
    logic [CW-1:0]   upd_cnt;

    // Low bits of a slot number that select its leaf.
    function automatic logic [LW-1:0] slot_leaf(input logic [csa_pkg::SLOT_W-1:0] s);
        logic [CMPW-1:0] s_ext;
        s_ext = CMPW'(s);
        return s_ext[LW-1:0];
    endfunction

    // Tree of free counts.
    csa_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Helper values for the sweep, the walk and the update.
    always_comb
    begin
        cfg_ext      = CMPW'(slots_in_use);
        slot_ext     = CMPW'(slot_reg);
        leaf_ext     = CMPW'(leaf_reg[LW-1:0]);
        sw_diff      = n_reg - sw_lo_reg;
        if (n_reg <= sw_lo_reg)
        begin
            sw_cnt = '0;
        end
        else if (sw_diff >= sw_span_reg)
        begin
            sw_cnt = sw_span_reg;
        end
        else
        begin
            sw_cnt = sw_diff;
        end
        sw_inc       = {1'b0, sw_idx_reg} + (NW+1)'(1);
        sw_level_end = ((sw_idx_reg & sw_inc[NW-1:0]) == '0);
        sib_addr     = {node_reg[NW-1:1], 1'b1};
        left_addr    = {node_reg[NW-2:0], 1'b0};
        if (func_reg == csa_pkg::FUNC_RELEASE)
        begin
            upd_cnt = ram_rdata + CW'(1);
        end
        else
        begin
            upd_cnt = ram_rdata - CW'(1);
        end
    end

    // Memory port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = upd_cnt;
        ram_re    = 1'b0;
        ram_raddr = node_reg;
        case (cmd.op)
            csa_pkg::OP_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sw_idx_reg;
                ram_wdata = sw_cnt;
            end
            csa_pkg::OP_READ_NODE:
            begin
                ram_re = 1'b1;
            end
            csa_pkg::OP_TO_SIB:
            begin
                ram_re    = 1'b1;
                ram_raddr = sib_addr;
            end
            csa_pkg::OP_ROOT:
            begin
                ram_re    = 1'b1;
                ram_raddr = NW'(1);
            end
            csa_pkg::OP_READ_LEFT:
            begin
                ram_re    = 1'b1;
                ram_raddr = left_addr;
            end
            csa_pkg::OP_WRITE_UPD:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Slot count and clearing sweep.
    always_comb
    begin
        n_next       = n_reg;
        sw_idx_next  = sw_idx_reg;
        sw_lo_next   = sw_lo_reg;
        sw_span_next = sw_span_reg;
        case (cmd.op)
            csa_pkg::OP_CFG:
            begin
                if (cfg_ext == '0)
                begin
                    n_next = CW'(1);
                end
                else if (cfg_ext > CMPW'(MAX_SLOTS))
                begin
                    n_next = CW'(MAX_SLOTS);
                end
                else
                begin
                    n_next = cfg_ext[CW-1:0];
                end
                sw_idx_next  = NW'(DEPTH / 2);
                sw_lo_next   = '0;
                sw_span_next = CW'(1);
            end
            csa_pkg::OP_SWEEP:
            begin
                if (sw_level_end)
                begin
                    sw_idx_next  = {1'b0, sw_inc[NW:2]};
                    sw_lo_next   = '0;
                    sw_span_next = {sw_span_reg[CW-2:0], 1'b0};
                end
                else
                begin
                    sw_idx_next = sw_inc[NW-1:0];
                    sw_lo_next  = sw_lo_reg + sw_span_reg;
                end
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    // Request capture and tree walk.
    always_comb
    begin
        node_next = node_reg;
        leaf_next = leaf_reg;
        func_next = func_reg;
        slot_next = slot_reg;
        case (cmd.op)
            csa_pkg::OP_LOAD:
            begin
                func_next = func;
                slot_next = slot;
            end
            csa_pkg::OP_TO_SIB:
            begin
                node_next = sib_addr;
            end
            csa_pkg::OP_UP:
            begin
                node_next = {1'b0, node_reg[NW-1:1]};
            end
            csa_pkg::OP_ROOT:
            begin
                node_next = NW'(1);
            end
            csa_pkg::OP_DOWN_LEFT:
            begin
                node_next = left_addr;
            end
            csa_pkg::OP_DOWN_RIGHT:
            begin
                node_next = {node_reg[NW-2:0], 1'b1};
            end
            csa_pkg::OP_FOUND:
            begin
                leaf_next = node_reg;
            end
            csa_pkg::OP_WRITE_UPD:
            begin
                node_next = {1'b0, node_reg[NW-1:1]};
            end
            default:
            begin
                node_next = node_reg;
            end
        endcase
    end

    // Result word.
    always_comb
    begin
        done_next    = 1'b0;
        granted_next = granted_reg;
        status_next  = status_reg;
        if (cmd.op == csa_pkg::OP_RESULT)
        begin
            done_next   = 1'b1;
            status_next = cmd.st;
            if (cmd.st == csa_pkg::ST_GRANTED)
            begin
                granted_next = leaf_ext[csa_pkg::SLOT_W-1:0];
            end
            else
            begin
                granted_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= CW'(MAX_SLOTS);
            sw_idx_reg  <= NW'(DEPTH / 2);
            sw_lo_reg   <= '0;
            sw_span_reg <= CW'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            n_reg       <= n_next;
            sw_idx_reg  <= sw_idx_next;
            sw_lo_reg   <= sw_lo_next;
            sw_span_reg <= sw_span_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers; the node pointer starts at the requested leaf.
    always_ff @(posedge clk)
    begin
        if (cmd.op == csa_pkg::OP_LOAD)
        begin
            node_reg <= {1'b1, slot_leaf(slot)};
            leaf_reg <= {1'b1, slot_leaf(slot)};
        end
        else
        begin
            node_reg <= node_next;
            leaf_reg <= leaf_next;
        end
        func_reg    <= func_next;
        slot_reg    <= slot_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    // Status toward the controller.
    always_comb
    begin
        stat.cnt_nz     = (ram_rdata != '0);
        stat.at_root    = (node_reg == NW'(1));
        stat.is_left    = ~node_reg[0];
        stat.is_leaf    = node_reg[NW-1];
        stat.start_oob  = (slot_ext >= CMPW'(n_reg));
        stat.is_release = (func_reg == csa_pkg::FUNC_RELEASE);
        stat.sweep_last = (sw_idx_reg == NW'(1));
    end

    assign done         = done_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;

    // A result strobe follows every result command.
    a_result_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == csa_pkg::OP_RESULT |=> done_reg)
        else $error("result command did not raise the strobe");

    // Results never come in two consecutive cycles.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // An allocation never takes a count below zero.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == csa_pkg::OP_WRITE_UPD && func_reg == csa_pkg::FUNC_ALLOC
        |-> ram_rdata != '0)
        else $error("free count underflow on allocation");

    // Only a grant carries a nonzero slot number.
    a_granted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != csa_pkg::ST_GRANTED |-> granted_reg == '0)
        else $error("nonzero slot on a result that is not a grant");

endmodule

// ----- design/csa_ctrl.sv -----
// ----------------------------------------------------------------------------
// csa_ctrl
// Controller of the allocator: sequences the clearing sweep, the climb and
// descent through the count tree, the wrap search and the count update.
// ----------------------------------------------------------------------------
module csa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    output csa_pkg::cmd_t  cmd,
    input  csa_pkg::stat_t stat
);

    csa_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csa_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csa_pkg::S_INIT:
            begin
                if (!cfg_valid && stat.sweep_last)
                begin
                    state_next = csa_pkg::S_IDLE;
                end
            end
            csa_pkg::S_IDLE:
            begin
                if (cfg_valid)
                begin
                    state_next = csa_pkg::S_INIT;
                end
                else if (start)
                begin
                    state_next = csa_pkg::S_DISPATCH;
                end
            end
            csa_pkg::S_DISPATCH:
            begin
                if (stat.is_release)
                begin
                    state_next = stat.start_oob ? csa_pkg::S_IDLE : csa_pkg::S_REL_CHK;
                end
                else
                begin
                    state_next = stat.start_oob ? csa_pkg::S_WRAP_CHK : csa_pkg::S_UP_CHK;
                end
            end
            csa_pkg::S_REL_CHK:
            begin
                state_next = stat.cnt_nz ? csa_pkg::S_IDLE : csa_pkg::S_UPD_RD;
            end
            csa_pkg::S_UP_CHK:
            begin
                state_next = stat.cnt_nz ? csa_pkg::S_UPD_RD : csa_pkg::S_UP_STEP;
            end
            csa_pkg::S_UP_STEP:
            begin
                if (stat.at_root)
                begin
                    state_next = csa_pkg::S_WRAP_CHK;
                end
                else if (stat.is_left)
                begin
                    state_next = csa_pkg::S_SIB_CHK;
                end
            end
            csa_pkg::S_SIB_CHK:
            begin
                state_next = stat.cnt_nz ? csa_pkg::S_DOWN_STEP : csa_pkg::S_UP_STEP;
            end
            csa_pkg::S_DOWN_STEP:
            begin
                state_next = stat.is_leaf ? csa_pkg::S_UPD_RD : csa_pkg::S_DOWN_CHK;
            end
            csa_pkg::S_DOWN_CHK:
            begin
                state_next = csa_pkg::S_DOWN_STEP;
            end
            csa_pkg::S_WRAP_CHK:
            begin
                state_next = stat.cnt_nz ? csa_pkg::S_DOWN_STEP : csa_pkg::S_IDLE;
            end
            csa_pkg::S_UPD_RD:
            begin
                state_next = csa_pkg::S_UPD_WR;
            end
            csa_pkg::S_UPD_WR:
            begin
                state_next = stat.at_root ? csa_pkg::S_FINISH : csa_pkg::S_UPD_RD;
            end
            csa_pkg::S_FINISH:
            begin
                state_next = csa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = csa_pkg::S_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd.op    = csa_pkg::OP_NONE;
        cmd.st    = csa_pkg::ST_BAD;
        busy      = (state_reg != csa_pkg::S_IDLE) || cfg_valid;
        cfg_ready = (state_reg inside {csa_pkg::S_IDLE, csa_pkg::S_INIT});
        case (state_reg)
            csa_pkg::S_INIT:
            begin
                cmd.op = cfg_valid ? csa_pkg::OP_CFG : csa_pkg::OP_SWEEP;
            end
            csa_pkg::S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.op = csa_pkg::OP_CFG;
                end
                else if (start)
                begin
                    cmd.op = csa_pkg::OP_LOAD;
                end
            end
            csa_pkg::S_DISPATCH:
            begin
                if (stat.is_release)
                begin
                    cmd.op = stat.start_oob ? csa_pkg::OP_RESULT : csa_pkg::OP_READ_NODE;
                end
                else
                begin
                    cmd.op = stat.start_oob ? csa_pkg::OP_ROOT : csa_pkg::OP_READ_NODE;
                end
            end
            csa_pkg::S_REL_CHK:
            begin
                if (stat.cnt_nz)
                begin
                    cmd.op = csa_pkg::OP_RESULT;
                end
            end
            csa_pkg::S_UP_CHK:
            begin
                if (stat.cnt_nz)
                begin
                    cmd.op = csa_pkg::OP_FOUND;
                end
            end
            csa_pkg::S_UP_STEP:
            begin
                if (stat.at_root)
                begin
                    cmd.op = csa_pkg::OP_ROOT;
                end
                else if (stat.is_left)
                begin
                    cmd.op = csa_pkg::OP_TO_SIB;
                end
                else
                begin
                    cmd.op = csa_pkg::OP_UP;
                end
            end
            csa_pkg::S_SIB_CHK:
            begin
                if (!stat.cnt_nz)
                begin
                    cmd.op = csa_pkg::OP_UP;
                end
            end
            csa_pkg::S_DOWN_STEP:
            begin
                cmd.op = stat.is_leaf ? csa_pkg::OP_FOUND : csa_pkg::OP_READ_LEFT;
            end
            csa_pkg::S_DOWN_CHK:
            begin
                cmd.op = stat.cnt_nz ? csa_pkg::OP_DOWN_LEFT : csa_pkg::OP_DOWN_RIGHT;
            end
            csa_pkg::S_WRAP_CHK:
            begin
                if (!stat.cnt_nz)
                begin
                    cmd.op = csa_pkg::OP_RESULT;
                    cmd.st = csa_pkg::ST_FULL;
                end
            end
            csa_pkg::S_UPD_RD:
            begin
                cmd.op = csa_pkg::OP_READ_NODE;
            end
            csa_pkg::S_UPD_WR:
            begin
                cmd.op = csa_pkg::OP_WRITE_UPD;
            end
            csa_pkg::S_FINISH:
            begin
                cmd.op = csa_pkg::OP_RESULT;
                cmd.st = stat.is_release ? csa_pkg::ST_RELEASED : csa_pkg::ST_GRANTED;
            end
            default:
            begin
                cmd.op = csa_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ----- design/circular_next_free_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// circular_next_free_slot_allocator
// Grants the first free slot at or after a preferred slot, wrapping to slot
// 0, or frees a slot, using a tree of free-slot counts held in a RAM.
// ----------------------------------------------------------------------------
//
//  channel   handshake               word
//  --------  ----------------------  ------------------------------------
//  request   start / busy            func, slot
//  result    done (one-cycle strobe) granted_slot, status
//  config    cfg_valid / cfg_ready   slots_in_use
//
// A request climbs the count tree from the start slot, wraps to the root when
// nothing is free above it, descends to the first free leaf and then updates the
// counts with a read and a write per level on the single RAM port pair.
// After reset, and after each write of slots_in_use, a clearing pass rebuilds
// the tree while busy stays high.
// A result is flagged by done for one cycle and cannot be stalled; the next
// request is taken in that same cycle.
// ----------------------------------------------------------------------------
module circular_next_free_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       func,
    input  logic [csa_pkg::SLOT_W-1:0] slot,
    output logic                       done,
    output logic [csa_pkg::SLOT_W-1:0] granted_slot,
    output logic [1:0]                 status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [csa_pkg::CFG_W-1:0]  slots_in_use
);

    csa_pkg::cmd_t    cmd;
    csa_pkg::stat_t   stat;
    csa_pkg::status_t status_code;

    // Sequencer.
    csa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Count tree and result registers.
    csa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (func),
        .slot         (slot),
        .slots_in_use (slots_in_use),
        .done         (done),
        .granted_slot (granted_slot),
        .status       (status_code)
    );

    assign status = status_code;

endmodule
